// ===== src/ttsc_pkg.sv =====
// Shared types, constants and helper functions of the template-to-script converter.
package ttsc_pkg;

  // Default lookahead for the longest delimiter.
  localparam int unsigned MAX_DELIM_DEF = 4;

  // Field and register widths.
  localparam int unsigned DELIM_W  = 32;
  localparam int unsigned DLEN_W   = 3;
  localparam int unsigned DCNT_W   = 4;
  localparam int unsigned IDX_W    = 4;
  localparam int unsigned CFG_IDX_W = 2;

  // Depth of the command queue between front and back end.
  localparam int unsigned QUEUE_DEPTH = 4;

  // Length of the put-command opener.
  localparam int unsigned PUT_LEN = 10;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_START_DELIM     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_DELIM_LEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_END_DELIM       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_END_DELIM_LEN   = 2'd3;

  // Register reset values.
  localparam logic [DELIM_W-1:0] START_DELIM_RST = 32'h0000_3F3C;
  localparam logic [DELIM_W-1:0] END_DELIM_RST   = 32'h0000_3E3F;
  localparam logic [DLEN_W-1:0]  DELIM_LEN_RST   = 3'd2;

  // Character codes.
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;

  // One template byte.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  // One script byte.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_item_t;

  // Expansion command for one token: opener, up to two head bytes,
  // a delimiter copy and a trailing opener, in that order.
  typedef struct packed {
    logic              put_pre;
    logic              put_post;
    logic              last;
    logic [1:0]        head_n;
    logic [7:0]        head0;
    logic [7:0]        head1;
    logic              delim_end;
    logic [DCNT_W-1:0] delim_n;
  } tok_cmd_t;

  // Byte i of a delimiter word; bytes past the fourth read as zero.
  function automatic logic [7:0] delim_byte(logic [DELIM_W-1:0] d, logic [DCNT_W-1:0] i);
    return 8'(d >> {i, 3'b000});
  endfunction

  // Effective delimiter length: zero counts as one, capped at the lookahead.
  function automatic logic [DCNT_W-1:0] eff_len(logic [DLEN_W-1:0] len, int unsigned maxd);
    logic [DCNT_W-1:0] l;
    l = DCNT_W'(len);
    if (l == '0) l = DCNT_W'(1);
    if (l > DCNT_W'(maxd)) l = DCNT_W'(maxd);
    return l;
  endfunction

  // Characters that need a backslash inside a put string.
  function automatic logic is_special(logic [7:0] c);
    return (c == CH_LBRACE) || (c == CH_RBRACE) || (c == CH_DOLLAR) ||
           (c == CH_LBRACK) || (c == CH_RBRACK) || (c == CH_QUOTE);
  endfunction

  // Character i of the put-command opener.
  function automatic logic [7:0] put_char(logic [IDX_W-1:0] i);
    logic [7:0] c;
    case (i)
      4'd0:    c = 8'h77;  // w
      4'd1:    c = 8'h65;  // e
      4'd2:    c = 8'h62;  // b
      4'd3:    c = 8'h3A;  // :
      4'd4:    c = 8'h3A;  // :
      4'd5:    c = 8'h70;  // p
      4'd6:    c = 8'h75;  // u
      4'd7:    c = 8'h74;  // t
      4'd8:    c = 8'h20;  // space
      default: c = CH_QUOTE;
    endcase
    return c;
  endfunction

endpackage

// ===== src/ttsc_front.sv =====
// Front end: lookahead window, token classification and nesting state.
module ttsc_front #(
  parameter int unsigned MaxDelim = ttsc_pkg::MAX_DELIM_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  ttsc_pkg::in_item_t             in_data_i,
  input  logic [ttsc_pkg::DELIM_W-1:0]   start_delim_i,
  input  logic [ttsc_pkg::DCNT_W-1:0]    start_len_i,
  input  logic [ttsc_pkg::DELIM_W-1:0]   end_delim_i,
  input  logic [ttsc_pkg::DCNT_W-1:0]    end_len_i,
  output logic                           cmd_valid_o,
  output ttsc_pkg::tok_cmd_t             cmd_o,
  input  logic                           cmd_full_i
);
  import ttsc_pkg::*;

  localparam int unsigned WinLen = MaxDelim + 1;
  localparam int unsigned CntW   = $clog2(WinLen + 1);

  logic [8*WinLen-1:0] win_q, win_d, win_s;
  logic [CntW-1:0]     cnt_q, cnt_d, cnt_s, used;
  logic                drain_q, drain_d;
  logic                first_q, first_d, first_t;
  logic [15:0]         depth_q, depth_d, depth_t;
  logic                ms0, ms1, me0, me1;
  logic                tok_rdy, end_rdy, push, accept, full_win;
  logic [7:0]          c;
  tok_cmd_t            tok_cmd, end_cmd;

  assign c = win_q[7:0];

  // Delimiter matches at the head of the window and one byte further in.
  always_comb begin
    ms0 = 1'b1;
    ms1 = 1'b1;
    me0 = 1'b1;
    me1 = 1'b1;
    for (int i = 0; i < MaxDelim; i++) begin
      if (DCNT_W'(i) < start_len_i) begin
        if (!(CntW'(i) < cnt_q) ||
            win_q[8*i +: 8] != delim_byte(start_delim_i, DCNT_W'(i))) ms0 = 1'b0;
        if (!(CntW'(i + 1) < cnt_q) ||
            win_q[8*(i+1) +: 8] != delim_byte(start_delim_i, DCNT_W'(i))) ms1 = 1'b0;
      end
      if (DCNT_W'(i) < end_len_i) begin
        if (!(CntW'(i) < cnt_q) ||
            win_q[8*i +: 8] != delim_byte(end_delim_i, DCNT_W'(i))) me0 = 1'b0;
        if (!(CntW'(i + 1) < cnt_q) ||
            win_q[8*(i+1) +: 8] != delim_byte(end_delim_i, DCNT_W'(i))) me1 = 1'b0;
      end
    end
  end

  // Classify the head token into an expansion command.
  always_comb begin
    tok_cmd = '0;
    used    = CntW'(1);
    depth_t = depth_q;
    first_t = first_q;
    if (c == CH_BSLASH) begin
      tok_cmd.put_pre = first_q;
      first_t         = 1'b0;
      tok_cmd.head0   = CH_BSLASH;
      tok_cmd.head1   = CH_BSLASH;
      tok_cmd.head_n  = 2'd1;
      if (ms1) begin
        tok_cmd.delim_n = start_len_i;
        used            = CntW'(start_len_i + 1'b1);
      end else if (me1) begin
        tok_cmd.delim_end = 1'b1;
        tok_cmd.delim_n   = end_len_i;
        used              = CntW'(end_len_i + 1'b1);
      end else if (depth_q == '0) begin
        // A lone backslash in text is doubled.
        tok_cmd.head_n = 2'd2;
      end
    end else if (ms0) begin
      used = CntW'(start_len_i);
      if (depth_q == 16'hFFFF) begin
        tok_cmd.delim_n = start_len_i;
      end else begin
        depth_t = depth_q + 16'd1;
        if (depth_q == '0) begin
          // Entering the outermost tag closes the put string.
          first_t = 1'b0;
          if (first_q) begin
            tok_cmd.head0  = CH_NL;
            tok_cmd.head_n = 2'd1;
          end else begin
            tok_cmd.head0  = CH_QUOTE;
            tok_cmd.head1  = CH_NL;
            tok_cmd.head_n = 2'd2;
          end
        end else begin
          tok_cmd.delim_n = start_len_i;
        end
      end
    end else if (me0) begin
      tok_cmd.put_pre = first_q;
      first_t         = 1'b0;
      used            = CntW'(end_len_i);
      if (depth_q == 16'd1) begin
        depth_t          = '0;
        tok_cmd.head0    = CH_NL;
        tok_cmd.head_n   = 2'd1;
        tok_cmd.put_post = 1'b1;
      end else begin
        if (depth_q > 16'd1) depth_t = depth_q - 16'd1;
        tok_cmd.delim_end = 1'b1;
        tok_cmd.delim_n   = end_len_i;
      end
    end else begin
      tok_cmd.put_pre = first_q;
      first_t         = 1'b0;
      if (depth_q == '0 && is_special(c)) begin
        tok_cmd.head0  = CH_BSLASH;
        tok_cmd.head1  = c;
        tok_cmd.head_n = 2'd2;
      end else begin
        tok_cmd.head0  = c;
        tok_cmd.head_n = 2'd1;
      end
    end
  end

  // Closing quote of the script.
  always_comb begin
    end_cmd        = '0;
    end_cmd.head0  = CH_QUOTE;
    end_cmd.head_n = 2'd1;
    end_cmd.last   = 1'b1;
  end

  // Handshake: a full window must lose its head token before it takes a byte.
  assign full_win    = (cnt_q == CntW'(WinLen));
  assign tok_rdy     = full_win || (drain_q && cnt_q != '0);
  assign end_rdy     = drain_q && cnt_q == '0;
  assign push        = (tok_rdy || end_rdy) && !cmd_full_i;
  assign in_stall_o  = drain_q || (full_win && !push);
  assign accept      = in_valid_i && !in_stall_o;
  assign cmd_valid_o = push;
  assign cmd_o       = end_rdy ? end_cmd : tok_cmd;

  // Window consume, append and stream state update.
  always_comb begin
    win_s   = win_q;
    cnt_s   = cnt_q;
    depth_d = depth_q;
    first_d = first_q;
    drain_d = drain_q;
    if (push && tok_rdy) begin
      win_s   = win_q >> {used, 3'b000};
      cnt_s   = cnt_q - used;
      depth_d = depth_t;
      first_d = first_t;
    end
    if (push && end_rdy) begin
      win_s   = '0;
      cnt_s   = '0;
      depth_d = '0;
      first_d = 1'b1;
      drain_d = 1'b0;
    end
    win_d = win_s;
    cnt_d = cnt_s;
    if (accept) begin
      for (int i = 0; i < WinLen; i++) begin
        if (CntW'(i) == cnt_s) win_d[8*i +: 8] = in_data_i.in_byte;
      end
      cnt_d = cnt_s + CntW'(1);
      if (in_data_i.in_last) drain_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q   <= '0;
      cnt_q   <= '0;
      depth_q <= '0;
      first_q <= 1'b1;
      drain_q <= 1'b0;
    end else begin
      win_q   <= win_d;
      cnt_q   <= cnt_d;
      depth_q <= depth_d;
      first_q <= first_d;
      drain_q <= drain_d;
    end
  end

endmodule

// ===== src/ttsc_queue.sv =====
// Short command queue between the front end and the back end.
module ttsc_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  ttsc_pkg::tok_cmd_t data_i,
  output logic               full_o,
  output logic               valid_o,
  output ttsc_pkg::tok_cmd_t data_o,
  input  logic               pop_i
);
  import ttsc_pkg::*;

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  tok_cmd_t        mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

// ===== src/ttsc_back.sv =====
// Back end: serializes expansion commands into script bytes, one per unstalled cycle.
module ttsc_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cmd_valid_i,
  input  ttsc_pkg::tok_cmd_t           cmd_i,
  output logic                         cmd_pop_o,
  input  logic [ttsc_pkg::DELIM_W-1:0] start_delim_i,
  input  logic [ttsc_pkg::DELIM_W-1:0] end_delim_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output ttsc_pkg::out_item_t          out_data_o
);
  import ttsc_pkg::*;

  // Phases of one command.
  localparam logic [1:0] PH_PRE   = 2'd0;
  localparam logic [1:0] PH_HEAD  = 2'd1;
  localparam logic [1:0] PH_DELIM = 2'd2;
  localparam logic [1:0] PH_POST  = 2'd3;

  logic             started_q;
  logic [1:0]       phase_q, entry, cur, nxt;
  logic [IDX_W-1:0] idx_q;
  logic             out_valid_q;
  out_item_t        out_q;
  logic [7:0]       ch;
  logic             end_ph, nxt_ok, done, advance, has_head, has_delim;

  assign has_head  = (cmd_i.head_n != '0);
  assign has_delim = (cmd_i.delim_n != '0);

  // First nonempty phase of the command at the queue head.
  always_comb begin
    if (cmd_i.put_pre) entry = PH_PRE;
    else if (has_head) entry = PH_HEAD;
    else if (has_delim) entry = PH_DELIM;
    else entry = PH_POST;
  end

  assign cur = started_q ? phase_q : entry;

  // Byte of the current phase and the phase that follows it.
  always_comb begin
    unique case (cur)
      PH_PRE: begin
        ch     = put_char(idx_q);
        end_ph = (idx_q == IDX_W'(PUT_LEN - 1));
        nxt_ok = has_head || has_delim || cmd_i.put_post;
        nxt    = has_head ? PH_HEAD : (has_delim ? PH_DELIM : PH_POST);
      end
      PH_HEAD: begin
        ch     = idx_q[0] ? cmd_i.head1 : cmd_i.head0;
        end_ph = (idx_q == {2'b00, cmd_i.head_n} - IDX_W'(1));
        nxt_ok = has_delim || cmd_i.put_post;
        nxt    = has_delim ? PH_DELIM : PH_POST;
      end
      PH_DELIM: begin
        ch     = cmd_i.delim_end ? delim_byte(end_delim_i, idx_q)
                                 : delim_byte(start_delim_i, idx_q);
        end_ph = (idx_q == cmd_i.delim_n - DCNT_W'(1));
        nxt_ok = cmd_i.put_post;
        nxt    = PH_POST;
      end
      PH_POST: begin
        ch     = put_char(idx_q);
        end_ph = (idx_q == IDX_W'(PUT_LEN - 1));
        nxt_ok = 1'b0;
        nxt    = PH_POST;
      end
      default: begin
        ch     = '0;
        end_ph = 1'b1;
        nxt_ok = 1'b0;
        nxt    = PH_POST;
      end
    endcase
  end

  assign advance     = cmd_valid_i && (!out_valid_q || !out_stall_i);
  assign done        = end_ph && !nxt_ok;
  assign cmd_pop_o   = advance && done;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Sequencer and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q   <= 1'b0;
      phase_q     <= PH_PRE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_q <= 1'b1;
        if (end_ph) begin
          idx_q <= '0;
          if (done) begin
            started_q <= 1'b0;
          end else begin
            started_q <= 1'b1;
            phase_q   <= nxt;
          end
        end else begin
          idx_q     <= idx_q + IDX_W'(1);
          started_q <= 1'b1;
          phase_q   <= cur;
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q.out_byte <= ch;
      out_q.out_last <= cmd_i.last && done;
    end
  end

endmodule

// ===== src/template_tag_to_script_converter_core.sv =====
// Top level of the template-to-script converter: configuration registers and the two ends.
//
//   channel | direction | handshake                | payload
//   in      | input     | in_valid_i / in_stall_o   | in_data_i  (in_byte, in_last)
//   out     | output    | out_valid_o / out_stall_i | out_data_o (out_byte, out_last)
//   cfg     | input     | cfg_we_i                  | cfg_idx_i, cfg_data_i
//
// The front end takes one template byte per cycle while the command queue has room.
// Each token expands to 1 to 11 + MaxDelim script bytes (15 by default), sent from the
// output register one per unstalled cycle, so script length sets the sustained rate.
// After a transfer with in_last the input stalls until the remaining tokens (up to
// MaxDelim + 1) and then the closing quote have entered the queue; a full queue delays this.
// Reset loads the default delimiters and clears the stream state; there is no
// clearing pass.
module template_tag_to_script_converter_core #(
  parameter int unsigned MaxDelim = ttsc_pkg::MAX_DELIM_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  ttsc_pkg::in_item_t             in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output ttsc_pkg::out_item_t            out_data_o,
  input  logic                           cfg_we_i,
  input  logic [ttsc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ttsc_pkg::DELIM_W-1:0]   cfg_data_i
);
  import ttsc_pkg::*;

  logic [DELIM_W-1:0] start_delim_q, end_delim_q;
  logic [DLEN_W-1:0]  start_len_q, end_len_q;
  logic [DCNT_W-1:0]  start_len, end_len;
  logic               fc_valid, q_full, q_valid, q_pop;
  tok_cmd_t           fc_cmd, q_cmd;

  // Configuration register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_delim_q <= START_DELIM_RST;
      start_len_q   <= DELIM_LEN_RST;
      end_delim_q   <= END_DELIM_RST;
      end_len_q     <= DELIM_LEN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_START_DELIM:     start_delim_q <= cfg_data_i;
        REG_START_DELIM_LEN: start_len_q   <= cfg_data_i[DLEN_W-1:0];
        REG_END_DELIM:       end_delim_q   <= cfg_data_i;
        REG_END_DELIM_LEN:   end_len_q     <= cfg_data_i[DLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Lengths as used by the matcher.
  assign start_len = eff_len(start_len_q, MaxDelim);
  assign end_len   = eff_len(end_len_q, MaxDelim);

  ttsc_front #(
    .MaxDelim(MaxDelim)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .start_delim_i(start_delim_q),
    .start_len_i  (start_len),
    .end_delim_i  (end_delim_q),
    .end_len_i    (end_len),
    .cmd_valid_o  (fc_valid),
    .cmd_o        (fc_cmd),
    .cmd_full_i   (q_full)
  );

  ttsc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (fc_valid),
    .data_i (fc_cmd),
    .full_o (q_full),
    .valid_o(q_valid),
    .data_o (q_cmd),
    .pop_i  (q_pop)
  );

  ttsc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (q_valid),
    .cmd_i        (q_cmd),
    .cmd_pop_o    (q_pop),
    .start_delim_i(start_delim_q),
    .end_delim_i  (end_delim_q),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

// ===== src/ttsc_checker.sv =====
// Port-level checks of the converter and their attachment to the top level.
module ttsc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input ttsc_pkg::in_item_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input ttsc_pkg::out_item_t out_data_o
);
  import ttsc_pkg::*;

  // A stalled result stays offered unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // The end of a script is always its closing quote.
  a_last_quote: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.out_last |-> out_data_o.out_byte == CH_QUOTE)
    else $error("script end is not a quote");

  // The end of a template holds off input while the window drains.
  a_drain_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.in_last |=> in_stall_o)
    else $error("input taken during drain");

  // Two script ends never follow each other directly.
  a_no_double_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && out_data_o.out_last |=>
      !(out_valid_o && out_data_o.out_last))
    else $error("empty script between two ends");

endmodule

bind template_tag_to_script_converter_core ttsc_checker u_ttsc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .in_data_i  (in_data_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o)
);
